>>> rtl/skt_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types for the sorted key table
package skt_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int FILL_W   = 7;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} skt_op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} skt_status_t;

	// compare flags handed from one cell to the next one up
	typedef struct packed {
		logic gt;
		logic eq;
	} skt_link_t;

	// per-cell view of the fill count
	typedef struct packed {
		logic occ;
		logic at_end;
	} skt_cell_ctl_t;

endpackage

>>> rtl/skt_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and responses
interface skt_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [skt_pkg::KEY_W-1:0] key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

interface skt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [skt_pkg::POS_W-1:0]  position;
	logic [skt_pkg::FILL_W-1:0] fill_count;

	modport source (output valid, output status, output position, output fill_count,
		input ready);
	modport sink   (input valid, input status, input position, input fill_count,
		output ready);
endinterface

>>> rtl/skt_cell.sv
`timescale 1ns / 1ps
// one table cell: holds a key, compares it, shifts up on insert
module skt_cell (
	input  logic                      clk,
	input  skt_pkg::skt_cell_ctl_t    ctl,
	input  logic [skt_pkg::KEY_W-1:0] probe,
	input  logic                      ins_en,
	input  skt_pkg::skt_link_t        link_in,
	input  logic [skt_pkg::KEY_W-1:0] key_in,
	output skt_pkg::skt_link_t        link_out,
	output logic [skt_pkg::KEY_W-1:0] key_out,
	output logic                      slot_hit,
	output logic                      find_hit
);

	logic [skt_pkg::KEY_W-1:0] key_q;

	always_comb begin
		link_out.gt = ctl.occ && ($signed(key_q) > $signed(probe));
		link_out.eq = ctl.occ && (key_q == probe);
		// new key lands where the lower neighbor is not greater and this one is, or at the end
		slot_hit = !link_in.gt && (link_out.gt || ctl.at_end);
		find_hit = link_out.eq && !link_in.eq;
	end

	assign key_out = key_q;

	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (link_in.gt) begin
				key_q <= key_in;
			end else if (slot_hit) begin
				key_q <= probe;
			end
		end
	end

endmodule

>>> rtl/sorted_key_table.sv
`timescale 1ns / 1ps
// top level of the sorted key table: cell row, fill count and response register
//
// channel  dir  fields                          transfer when
// req      in   func, key                       req.valid && req.ready
// rsp      out  status, position, fill_count    rsp.valid && rsp.ready
//
// each item is first captured into the capture stage; then all
// cells compare against the key in parallel and the row shifts up on insert
// the response register is loaded in that compare step; a new request is taken
// in the cycle after, even while the previous response still waits
// a stalled response holds the item in the capture stage until it can be loaded
// reset clears the fill count and handshake state; cell keys are not reset
module sorted_key_table (
	input  logic             clk,
	input  logic             arst_n,
	skt_req_if.sink          req,
	skt_rsp_if.source        rsp
);

	localparam int N = skt_pkg::CAPACITY;

	// capture stage
	logic                          busy_q;
	logic                          func_s1;
	logic [skt_pkg::KEY_W-1:0]     key_s1;

	// fill count
	logic [skt_pkg::CNT_W-1:0]     count_q;

	// response register
	logic                          rsp_valid_q;
	skt_pkg::skt_status_t          status_q;
	logic [skt_pkg::POS_W-1:0]     position_q;
	logic [skt_pkg::FILL_W-1:0]    fill_q;

	// cell row wiring
	skt_pkg::skt_cell_ctl_t        ctl     [N];
	skt_pkg::skt_link_t            link    [N+1];
	logic [skt_pkg::KEY_W-1:0]     chain   [N+1];
	logic [N-1:0]                  slot_hit;
	logic [N-1:0]                  find_hit;

	logic                          full;
	logic                          done;
	logic                          ins_ok;
	logic [skt_pkg::POS_W-1:0]     slot_pos;
	logic [skt_pkg::POS_W-1:0]     find_pos;

	assign full   = (count_q == skt_pkg::CNT_W'(N));
	// item finishes when the response register is free or being drained
	assign done   = busy_q && (!rsp_valid_q || rsp.ready);
	assign ins_ok = done && (func_s1 == skt_pkg::OP_INSERT) && !full;

	assign req.ready = !busy_q;

	// bottom of the chain: nothing below cell zero
	assign link[0]  = '0;
	assign chain[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		always_comb begin
			ctl[i].occ    = (skt_pkg::CNT_W'(i) < count_q);
			ctl[i].at_end = (skt_pkg::CNT_W'(i) == count_q);
		end

		skt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.probe    (key_s1),
			.ins_en   (ins_ok),
			.link_in  (link[i]),
			.key_in   (chain[i]),
			.link_out (link[i+1]),
			.key_out  (chain[i+1]),
			.slot_hit (slot_hit[i]),
			.find_hit (find_hit[i])
		);
	end

	// one-hot to index, kept to the position width
	always_comb begin
		slot_pos = '0;
		find_pos = '0;
		for (int i = 0; i < N; i++) begin
			if (slot_hit[i]) begin
				slot_pos = slot_pos | skt_pkg::POS_W'(i);
			end
			if (find_hit[i]) begin
				find_pos = find_pos | skt_pkg::POS_W'(i);
			end
		end
	end

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			key_s1  <= req.key;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_ok) begin
			count_q <= count_q + 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (func_s1 == skt_pkg::OP_INSERT) begin
				if (full) begin
					status_q   <= skt_pkg::ST_FULL;
					position_q <= '0;
					fill_q     <= skt_pkg::FILL_W'(count_q);
				end else begin
					status_q   <= skt_pkg::ST_DONE;
					position_q <= slot_pos;
					fill_q     <= skt_pkg::FILL_W'(count_q + 1'b1);
				end
			end else begin
				// sorted row: any equal key lies below every greater key
				if (|find_hit) begin
					status_q   <= skt_pkg::ST_DONE;
					position_q <= find_pos;
				end else begin
					status_q   <= skt_pkg::ST_MISS;
					position_q <= '0;
				end
				fill_q <= skt_pkg::FILL_W'(count_q);
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.position   = position_q;
	assign rsp.fill_count = fill_q;

	// fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= skt_pkg::CNT_W'(N))
		else $error("fill count above capacity");

	// an accepted insert lands in exactly one cell
	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |-> $onehot(slot_hit))
		else $error("insert slot not unique");

	// a lookup hits at most one first-equal cell
	a_one_find: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(find_hit))
		else $error("more than one first match");

	// fill count moves only on a committed insert
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(ins_ok))
		else $error("fill count changed without insert");

	// a finished item is always followed by a pending response
	a_done_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> rsp_valid_q)
		else $error("finished item gave no response");

endmodule
